FILE: sv/odhm_pkg.sv
// shared constants and tables for the omni drive heading mixer
package odhm_pkg;

   localparam int CORDIC_STAGES_DEF = 16;
   localparam int ATAN_ENTRIES      = 24;

   localparam int HEAD_W  = 13;
   localparam int POWER_W = 7;
   localparam int OUT_W   = 8;

   localparam int ANG_W  = 14;
   localparam int RED_W  = 12;
   localparam int D_W    = 11;
   localparam int ZW     = 32;
   localparam int XW     = 34;
   localparam int Q15_W  = 17;
   localparam int MAG_W  = 16;
   localparam int NUM_W  = 22;
   localparam int QUO_W  = 7;

   localparam logic signed [XW-1:0]  CORDIC_GAIN_Q30 = 34'sd652032874;
   localparam logic [MAG_W-1:0]      Q15_ONE         = 16'd32768;

   function automatic logic signed [ZW-1:0] atan_q22(input int idx);
      logic signed [ZW-1:0] val;
      case (idx)
         0:       val = 32'sd188743680;
         1:       val = 32'sd111421900;
         2:       val = 32'sd58872272;
         3:       val = 32'sd29884485;
         4:       val = 32'sd15000234;
         5:       val = 32'sd7507429;
         6:       val = 32'sd3754631;
         7:       val = 32'sd1877430;
         8:       val = 32'sd938729;
         9:       val = 32'sd469366;
         10:      val = 32'sd234683;
         11:      val = 32'sd117342;
         12:      val = 32'sd58671;
         13:      val = 32'sd29335;
         14:      val = 32'sd14668;
         15:      val = 32'sd7334;
         16:      val = 32'sd3667;
         17:      val = 32'sd1833;
         18:      val = 32'sd917;
         19:      val = 32'sd458;
         20:      val = 32'sd229;
         21:      val = 32'sd115;
         22:      val = 32'sd57;
         23:      val = 32'sd29;
         default: val = 32'sd0;
      endcase
      return val;
   endfunction

endpackage

FILE: sv/omni_drive_heading_mixer.sv
// omni drive heading mixer: pipelined cordic, quadrant fold, power scaling by restoring divide
//
// usage
//   input channel: a transfer happens on a rising clock edge with start high and busy low;
//   busy is always low, so a new heading and power limit can be given every cycle
//   result channel: rsp_valid is high for exactly one cycle with rsp_nw_power and
//   rsp_ne_power; the receiver takes the result in that cycle and cannot hold it off
//   registers from the input transfer to rsp_valid, in order:
//   (input register, angle fold, angle scale, one register per cordic iteration,
//   rounding, mixing, seven restoring divide steps, output register)
//   throughput: one item per cycle, set by the fully unrolled cordic and divider
//   pipelines, each iteration or quotient bit having its own register stage
//   results leave in the order the items came in, one result per item
//   reset: synchronous, active high; clears every valid bit so no result is
//   produced from items in flight; payload registers are not cleared
//   the pipeline never stalls, since the receiver cannot refuse a result
module omni_drive_heading_mixer
   import odhm_pkg::*;
#(
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic signed [HEAD_W-1:0]  req_heading_tenths,
   input  logic [POWER_W-1:0]        req_max_power,
   output logic                      rsp_valid,
   output logic signed [OUT_W-1:0]   rsp_nw_power,
   output logic signed [OUT_W-1:0]   rsp_ne_power
);

   localparam int NUM_ITER = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;

   // input register
   logic                     in_valid_ff;
   logic signed [HEAD_W-1:0] in_head_ff;
   logic [POWER_W-1:0]       in_pow_ff;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= start & ~busy;
      end
      in_head_ff <= req_heading_tenths;
      in_pow_ff  <= req_max_power;
   end

   // angle fold into quadrant and residual
   logic                     fold_valid_ff;
   logic signed [D_W-1:0]    fold_d_ff;
   logic signed [D_W-1:0]    fold_d_in;
   logic [1:0]               fold_q_ff;
   logic [1:0]               fold_q_in;
   logic [POWER_W-1:0]       fold_pow_ff;
   logic signed [ANG_W-1:0]  ang;
   logic signed [ANG_W-1:0]  red;
   logic [RED_W-1:0]         red_u;
   logic [2:0]               quad_f;
   logic signed [RED_W:0]    quad_off;
   logic signed [RED_W:0]    d_full;

   always_comb begin
      ang = 14'sd450 - $signed({in_head_ff[HEAD_W-1], in_head_ff});
      if (ang < -14'sd3600) begin
         red = ang + 14'sd7200;
      end else if (ang < 14'sd0) begin
         red = ang + 14'sd3600;
      end else if (ang >= 14'sd3600) begin
         red = ang - 14'sd3600;
      end else begin
         red = ang;
      end
      red_u  = red[RED_W-1:0];
      quad_f = 3'(red_u >= 12'd450) + 3'(red_u >= 12'd1350)
             + 3'(red_u >= 12'd2250) + 3'(red_u >= 12'd3150);
      case (quad_f)
         3'd0:    quad_off = 13'sd0;
         3'd1:    quad_off = 13'sd900;
         3'd2:    quad_off = 13'sd1800;
         3'd3:    quad_off = 13'sd2700;
         default: quad_off = 13'sd3600;
      endcase
      d_full    = $signed({1'b0, red_u}) - quad_off;
      fold_d_in = d_full[D_W-1:0];
      fold_q_in = quad_f[1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fold_valid_ff <= 1'b0;
      end else begin
         fold_valid_ff <= in_valid_ff;
      end
      fold_d_ff   <= fold_d_in;
      fold_q_ff   <= fold_q_in;
      fold_pow_ff <= in_pow_ff;
   end

   // residual angle to 2^-22 degree units, d * 2^22 / 10 truncated toward zero
   logic [8:0]            d_mag;
   logic [D_W-1:0]        d_abs;
   logic [27:0]           z_whole;
   logic [25:0]           z_frac_p;
   logic [27:0]           z_mag;
   logic signed [ZW-1:0]  z_start;

   always_comb begin
      d_abs    = fold_d_ff[D_W-1] ? D_W'(-fold_d_ff) : D_W'(fold_d_ff);
      d_mag    = d_abs[8:0];
      z_whole  = 28'(d_mag) * 28'd419430;
      z_frac_p = 26'({d_mag, 1'b0}) * 26'd52429;
      z_mag    = z_whole + 28'(z_frac_p[25:18]);
      if (fold_d_ff[D_W-1]) begin
         z_start = -$signed({4'b0000, z_mag});
      end else begin
         z_start = $signed({4'b0000, z_mag});
      end
   end

   // cordic pipeline, index 0 is the scaled angle register
   logic                    cv_ff [NUM_ITER+1];
   logic signed [XW-1:0]    cx_ff [NUM_ITER+1];
   logic signed [XW-1:0]    cy_ff [NUM_ITER+1];
   logic signed [ZW-1:0]    cz_ff [NUM_ITER+1];
   logic [1:0]              cq_ff [NUM_ITER+1];
   logic [POWER_W-1:0]      cp_ff [NUM_ITER+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         cv_ff[0] <= 1'b0;
      end else begin
         cv_ff[0] <= fold_valid_ff;
      end
      cx_ff[0] <= CORDIC_GAIN_Q30;
      cy_ff[0] <= '0;
      cz_ff[0] <= z_start;
      cq_ff[0] <= fold_q_ff;
      cp_ff[0] <= fold_pow_ff;
   end

   for (genvar gi = 0; gi < NUM_ITER; gi++) begin : g_cordic
      logic signed [XW-1:0] xs;
      logic signed [XW-1:0] ys;
      logic signed [XW-1:0] x_in;
      logic signed [XW-1:0] y_in;
      logic signed [ZW-1:0] z_in;

      always_comb begin
         xs = cx_ff[gi] >>> gi;
         ys = cy_ff[gi] >>> gi;
         if (!cz_ff[gi][ZW-1]) begin
            x_in = cx_ff[gi] - ys;
            y_in = cy_ff[gi] + xs;
            z_in = cz_ff[gi] - atan_q22(gi);
         end else begin
            x_in = cx_ff[gi] + ys;
            y_in = cy_ff[gi] - xs;
            z_in = cz_ff[gi] + atan_q22(gi);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            cv_ff[gi+1] <= 1'b0;
         end else begin
            cv_ff[gi+1] <= cv_ff[gi];
         end
         cx_ff[gi+1] <= x_in;
         cy_ff[gi+1] <= y_in;
         cz_ff[gi+1] <= z_in;
         cq_ff[gi+1] <= cq_ff[gi];
         cp_ff[gi+1] <= cp_ff[gi];
      end
   end

   // round to q1.15 with clamp at +-1.0
   logic                     rnd_valid_ff;
   logic signed [Q15_W-1:0]  rnd_c_ff;
   logic signed [Q15_W-1:0]  rnd_s_ff;
   logic signed [Q15_W-1:0]  rnd_c_in;
   logic signed [Q15_W-1:0]  rnd_s_in;
   logic [1:0]               rnd_q_ff;
   logic [POWER_W-1:0]       rnd_pow_ff;
   logic signed [XW-1:0]     xr_sum;
   logic signed [XW-1:0]     yr_sum;
   logic signed [XW-16:0]    xr;
   logic signed [XW-16:0]    yr;

   always_comb begin
      xr_sum = cx_ff[NUM_ITER] + 34'sd16384;
      yr_sum = cy_ff[NUM_ITER] + 34'sd16384;
      xr     = xr_sum[XW-1:15];
      yr     = yr_sum[XW-1:15];
      if (xr > 19'sd32768) begin
         rnd_c_in = 17'sd32768;
      end else if (xr < -19'sd32768) begin
         rnd_c_in = -17'sd32768;
      end else begin
         rnd_c_in = xr[Q15_W-1:0];
      end
      if (yr > 19'sd32768) begin
         rnd_s_in = 17'sd32768;
      end else if (yr < -19'sd32768) begin
         rnd_s_in = -17'sd32768;
      end else begin
         rnd_s_in = yr[Q15_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rnd_valid_ff <= 1'b0;
      end else begin
         rnd_valid_ff <= cv_ff[NUM_ITER];
      end
      rnd_c_ff   <= rnd_c_in;
      rnd_s_ff   <= rnd_s_in;
      rnd_q_ff   <= cq_ff[NUM_ITER];
      rnd_pow_ff <= cp_ff[NUM_ITER];
   end

   // quadrant rotation, magnitudes, scale decision and dividends
   logic signed [Q15_W-1:0]  rot_c;
   logic signed [Q15_W-1:0]  rot_s;
   logic [Q15_W-1:0]         abs_c;
   logic [Q15_W-1:0]         abs_s;
   logic [MAG_W-1:0]         mag_c;
   logic [MAG_W-1:0]         mag_s;
   logic [MAG_W-1:0]         mag_max;
   logic                     do_scale;
   logic [NUM_W-1:0]         num_nw_in;
   logic [NUM_W-1:0]         num_ne_in;
   logic [MAG_W-1:0]         den_in;

   always_comb begin
      case (rnd_q_ff)
         2'd1: begin
            rot_c = -rnd_s_ff;
            rot_s = rnd_c_ff;
         end
         2'd2: begin
            rot_c = -rnd_c_ff;
            rot_s = -rnd_s_ff;
         end
         2'd3: begin
            rot_c = rnd_s_ff;
            rot_s = -rnd_c_ff;
         end
         default: begin
            rot_c = rnd_c_ff;
            rot_s = rnd_s_ff;
         end
      endcase
      abs_c    = rot_c[Q15_W-1] ? Q15_W'(-rot_c) : Q15_W'(rot_c);
      abs_s    = rot_s[Q15_W-1] ? Q15_W'(-rot_s) : Q15_W'(rot_s);
      mag_c    = abs_c[MAG_W-1:0];
      mag_s    = abs_s[MAG_W-1:0];
      mag_max  = (mag_s >= mag_c) ? mag_s : mag_c;
      do_scale = ((mag_c != '0) || (mag_s != '0))
               && ((rnd_pow_ff >= 7'd2)
                   || ((rnd_pow_ff == 7'd1) && (mag_c != Q15_ONE) && (mag_s != Q15_ONE)));
      if (do_scale) begin
         num_nw_in = NUM_W'(mag_s) * NUM_W'(rnd_pow_ff);
         num_ne_in = NUM_W'(mag_c) * NUM_W'(rnd_pow_ff);
         den_in    = mag_max;
      end else begin
         num_nw_in = NUM_W'(mag_s);
         num_ne_in = NUM_W'(mag_c);
         den_in    = Q15_ONE;
      end
   end

   // restoring divide pipeline, index 0 is the mixing register
   logic                 dv_ff   [QUO_W+1];
   logic [NUM_W-1:0]     drn_ff  [QUO_W+1];
   logic [NUM_W-1:0]     dre_ff  [QUO_W+1];
   logic [QUO_W-1:0]     dqn_ff  [QUO_W+1];
   logic [QUO_W-1:0]     dqe_ff  [QUO_W+1];
   logic [MAG_W-1:0]     dden_ff [QUO_W+1];
   logic                 dsn_ff  [QUO_W+1];
   logic                 dse_ff  [QUO_W+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff[0] <= 1'b0;
      end else begin
         dv_ff[0] <= rnd_valid_ff;
      end
      drn_ff[0]  <= num_nw_in;
      dre_ff[0]  <= num_ne_in;
      dqn_ff[0]  <= '0;
      dqe_ff[0]  <= '0;
      dden_ff[0] <= den_in;
      dsn_ff[0]  <= rot_s[Q15_W-1];
      dse_ff[0]  <= rot_c[Q15_W-1];
   end

   for (genvar gk = 0; gk < QUO_W; gk++) begin : g_div
      localparam int BIT = QUO_W - 1 - gk;
      logic [NUM_W-1:0]  trial;
      logic [NUM_W-1:0]  rn_in;
      logic [NUM_W-1:0]  re_in;
      logic [QUO_W-1:0]  qn_in;
      logic [QUO_W-1:0]  qe_in;

      always_comb begin
         trial = NUM_W'(dden_ff[gk]) << BIT;
         rn_in = drn_ff[gk];
         re_in = dre_ff[gk];
         qn_in = dqn_ff[gk];
         qe_in = dqe_ff[gk];
         if (drn_ff[gk] >= trial) begin
            rn_in      = drn_ff[gk] - trial;
            qn_in[BIT] = 1'b1;
         end
         if (dre_ff[gk] >= trial) begin
            re_in      = dre_ff[gk] - trial;
            qe_in[BIT] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[gk+1] <= 1'b0;
         end else begin
            dv_ff[gk+1] <= dv_ff[gk];
         end
         drn_ff[gk+1]  <= rn_in;
         dre_ff[gk+1]  <= re_in;
         dqn_ff[gk+1]  <= qn_in;
         dqe_ff[gk+1]  <= qe_in;
         dden_ff[gk+1] <= dden_ff[gk];
         dsn_ff[gk+1]  <= dsn_ff[gk];
         dse_ff[gk+1]  <= dse_ff[gk];
      end
   end

   // output register with sign restored
   logic                    out_valid_ff;
   logic signed [OUT_W-1:0] out_nw_ff;
   logic signed [OUT_W-1:0] out_ne_ff;
   logic signed [OUT_W-1:0] out_nw_in;
   logic signed [OUT_W-1:0] out_ne_in;

   always_comb begin
      out_nw_in = $signed({1'b0, dqn_ff[QUO_W]});
      out_ne_in = $signed({1'b0, dqe_ff[QUO_W]});
      if (dsn_ff[QUO_W]) begin
         out_nw_in = -out_nw_in;
      end
      if (dse_ff[QUO_W]) begin
         out_ne_in = -out_ne_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= dv_ff[QUO_W];
      end
      out_nw_ff <= out_nw_in;
      out_ne_ff <= out_ne_in;
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_nw_power = out_nw_ff;
   assign rsp_ne_power = out_ne_ff;

endmodule

FILE: bench/tb_omni_drive_heading_mixer.sv
// testbench for omni_drive_heading_mixer: directed and random headings against a predictor
module tb_omni_drive_heading_mixer
   import odhm_pkg::*;
();

   localparam int STAGES = CORDIC_STAGES_DEF;
   localparam longint GAIN_Q30 = 64'sd652032874;
   localparam longint UNIT_Q15 = 64'sd32768;

   typedef struct {
      logic signed [HEAD_W-1:0] heading;
      logic [POWER_W-1:0]       power;
      logic signed [OUT_W-1:0]  nw;
      logic signed [OUT_W-1:0]  ne;
   } wheel_pair_type;

   logic                     clock;
   logic                     reset;
   logic                     start;
   logic                     busy;
   logic signed [HEAD_W-1:0] req_heading_tenths;
   logic [POWER_W-1:0]       req_max_power;
   logic                     rsp_valid;
   logic signed [OUT_W-1:0]  rsp_nw_power;
   logic signed [OUT_W-1:0]  rsp_ne_power;

   wheel_pair_type expected_wheels[$];
   bit             took_item;
   int             mismatches;

   longint arc_q22 [0:ATAN_ENTRIES-1] = '{
      188743680, 111421900, 58872272, 29884485,
      15000234, 7507429, 3754631, 1877430,
      938729, 469366, 234683, 117342,
      58671, 29335, 14668, 7334,
      3667, 1833, 917, 458,
      229, 115, 57, 29
   };

   omni_drive_heading_mixer #(.CORDIC_STAGES(STAGES)) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_heading_tenths(req_heading_tenths),
      .req_max_power(req_max_power),
      .rsp_valid(rsp_valid),
      .rsp_nw_power(rsp_nw_power),
      .rsp_ne_power(rsp_ne_power)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   function automatic longint round_q15(input longint v);
      longint r;
      r = (v + 64'sd16384) >>> 15;
      if (r > UNIT_Q15) r = UNIT_Q15;
      if (r < -UNIT_Q15) r = -UNIT_Q15;
      return r;
   endfunction

   function automatic longint scale_toward_zero(input longint v, input longint num,
                                                input longint den);
      longint q;
      q = ((v < 0 ? -v : v) * num) / den;
      return v < 0 ? -q : q;
   endfunction

   function automatic wheel_pair_type mix_heading(input logic signed [HEAD_W-1:0] heading,
                                                  input logic [POWER_W-1:0] power);
      wheel_pair_type w;
      longint ang, red, qf, d, x, y, z, xs, ys, c0, s0, c, s, mc, ms, m, p, nwv, nev;
      int quad;
      ang = 450 - longint'(heading);
      red = ang % 3600;
      if (red < 0) red += 3600;
      qf = (red + 450) / 900;
      d = red - qf * 900;
      quad = int'(qf % 4);
      x = GAIN_Q30;
      y = 0;
      z = (d * 64'sd4194304) / 10;
      for (int i = 0; i < STAGES && i < ATAN_ENTRIES; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x -= ys;
            y += xs;
            z -= arc_q22[i];
         end else begin
            x += ys;
            y -= xs;
            z += arc_q22[i];
         end
      end
      c0 = round_q15(x);
      s0 = round_q15(y);
      case (quad)
         1: begin c = -s0; s = c0;  end
         2: begin c = -c0; s = -s0; end
         3: begin c = s0;  s = -c0; end
         default: begin c = c0; s = s0; end
      endcase
      mc = c < 0 ? -c : c;
      ms = s < 0 ? -s : s;
      p = longint'(power);
      if (mc < p * UNIT_Q15 && ms < p * UNIT_Q15 && (mc > 0 || ms > 0)) begin
         m = (ms >= mc) ? ms : mc;
         nwv = scale_toward_zero(s, p, m);
         nev = scale_toward_zero(c, p, m);
      end else begin
         nwv = scale_toward_zero(s, 1, UNIT_Q15);
         nev = scale_toward_zero(c, 1, UNIT_Q15);
      end
      w.heading = heading;
      w.power = power;
      w.nw = nwv[OUT_W-1:0];
      w.ne = nev[OUT_W-1:0];
      return w;
   endfunction

   // transfer bookkeeping and result checking
   always @(posedge clock) begin
      wheel_pair_type want;
      if (reset) begin
         took_item = 1'b0;
      end else begin
         if (rsp_valid) begin
            if (expected_wheels.size() == 0) begin
               $error("result with nothing pending: nw_power %0d ne_power %0d",
                      rsp_nw_power, rsp_ne_power);
               mismatches++;
            end else begin
               want = expected_wheels.pop_front();
               if (rsp_nw_power !== want.nw) begin
                  $error("nw_power heading %0d power %0d: expected %0d actual %0d",
                         want.heading, want.power, want.nw, rsp_nw_power);
                  mismatches++;
               end
               if (rsp_ne_power !== want.ne) begin
                  $error("ne_power heading %0d power %0d: expected %0d actual %0d",
                         want.heading, want.power, want.ne, rsp_ne_power);
                  mismatches++;
               end
            end
         end
         took_item = start && !busy;
         if (took_item)
            expected_wheels.push_back(mix_heading(req_heading_tenths, req_max_power));
      end
   end

   // called at a falling edge, returns at the falling edge after the transfer
   task automatic send_item(input logic signed [HEAD_W-1:0] heading,
                            input logic [POWER_W-1:0] power);
      start <= 1'b1;
      req_heading_tenths <= heading;
      req_max_power <= power;
      do @(negedge clock); while (!took_item);
   endtask

   task automatic sender_gap(input bit allowed);
      if (allowed && $urandom_range(0, 4) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
   endtask

   task automatic wait_for_results();
      start <= 1'b0;
      while (expected_wheels.size() != 0) @(negedge clock);
   endtask

   task automatic test_directed();
      int headings[16] = '{-4096, 4095, -3600, 3600, 0, 450, -450, 900,
                           1350, 1800, 2250, 2700, 3150, 449, 451, -1};
      int powers[5] = '{0, 1, 100, 127, 50};
      for (int i = 0; i < 16; i++)
         send_item(HEAD_W'(headings[i]), POWER_W'(powers[i % 5]));
      send_item(HEAD_W'(450), POWER_W'(0));
      send_item(HEAD_W'(-450), POWER_W'(127));
      send_item(HEAD_W'(1800), POWER_W'(0));
      send_item(HEAD_W'(2700), POWER_W'(1));
      send_item(HEAD_W'(-4096), POWER_W'(127));
      send_item(HEAD_W'(4095), POWER_W'(0));
      send_item(HEAD_W'(225), POWER_W'(100));
      send_item(HEAD_W'(0), POWER_W'(127));
   endtask

   task automatic test_random_in_range(input int count);
      bit gappy;
      gappy = 1'b1;
      for (int i = 0; i < count; i++) begin
         if (i % 64 == 0) gappy = $urandom_range(0, 2) != 0;
         sender_gap(gappy);
         send_item(HEAD_W'($urandom_range(0, 7200) - 3600), POWER_W'($urandom_range(0, 100)));
      end
   endtask

   task automatic test_full_width(input int count);
      bit gappy;
      gappy = 1'b0;
      for (int i = 0; i < count; i++) begin
         if (i % 64 == 0) gappy = $urandom_range(0, 2) != 0;
         sender_gap(gappy);
         send_item(HEAD_W'($urandom), POWER_W'($urandom));
      end
   endtask

   // headings around quadrant folds and the diagonals where the pairs tie
   task automatic test_fold_edges(input int count);
      int k;
      for (int i = 0; i < count; i++) begin
         k = $urandom_range(0, 18) - 9;
         sender_gap(1'b1);
         send_item(HEAD_W'(k * 450 + $urandom_range(0, 6) - 3),
                   POWER_W'($urandom_range(0, 127)));
      end
   endtask

   task automatic test_back_to_back(input int count);
      for (int i = 0; i < count; i++)
         send_item(HEAD_W'($urandom), POWER_W'($urandom_range(0, 127)));
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_heading_tenths = '0;
      req_max_power = '0;
      mismatches = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_random_in_range(800);
      wait_for_results();
      test_full_width(500);
      test_fold_edges(300);
      wait_for_results();
      test_back_to_back(325);
      start <= 1'b0;
      while (expected_wheels.size() != 0) @(negedge clock);
      repeat (STAGES + 20) @(negedge clock);
      if (mismatches == 0 && expected_wheels.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin
      #2000000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

FILE: sim.f
sv/odhm_pkg.sv
sv/omni_drive_heading_mixer.sv
bench/tb_omni_drive_heading_mixer.sv
